[hw/rtl/hbw_pkg.sv]
// Heartbeat watchdog package: widths, constants, operation codes and shared structs.
// No dependencies; used by every other file of the block.
package hbw_pkg;

  localparam int NUM_TASKS_DEF   = 5;
  localparam int TICKS_PER_SEC   = 1000;
  localparam int TICKS_PER_HOUR  = 3600000;
  localparam int MIN_HB_S        = 10;
  localparam int MIN_UP_H        = 5;
  localparam int HB_RST_S        = 10;
  localparam int UP_RST_H        = 5;

  localparam int OP_W            = 3;
  localparam int IDX_W           = 3;
  localparam int RUN_W           = 5;
  localparam int HB_S_W          = 16;
  localparam int UP_H_W          = 8;
  localparam int HB_CNT_W        = 26;
  localparam int UP_SUB_W        = 22;

  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  typedef enum logic [0:0] {
    REG_HB_PERIOD = 1'b0,
    REG_UP_PERIOD = 1'b1
  } reg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 3'd0,
    OP_HEARTBEAT  = 3'd1,
    OP_REGISTER   = 3'd2,
    OP_UNREGISTER = 3'd3,
    OP_DISABLE    = 3'd4,
    OP_KICK       = 3'd5
  } op_t;

  typedef struct packed {
    logic [HB_S_W-1:0] hb_period_s;
    logic [UP_H_W-1:0] up_period_h;
  } cfg_t;

  typedef struct packed {
    logic              service_watchdog;
    logic              reset_now;
    logic              failed;
    logic              report_valid;
    logic [RUN_W-1:0]  tasks_running;
    logic [UP_H_W-1:0] uplink_hours_left;
  } res_t;

endpackage

[hw/rtl/hbw_in_if.sv]
// Operation channel: valid/ready handshake carrying one watchdog operation per beat.
// Depends on hbw_pkg for field widths.
interface hbw_in_if;
  import hbw_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [IDX_W-1:0] task_index;

  modport source (output valid, output operation, output task_index, input ready);
  modport sink   (input valid, input operation, input task_index, output ready);
endinterface

[hw/rtl/hbw_out_if.sv]
// Result channel: valid/ready handshake carrying one watchdog result per beat.
// Depends on hbw_pkg for field widths.
interface hbw_out_if;
  import hbw_pkg::*;

  logic              valid;
  logic              ready;
  logic              service_watchdog;
  logic              reset_now;
  logic              failed;
  logic              report_valid;
  logic [RUN_W-1:0]  tasks_running;
  logic [UP_H_W-1:0] uplink_hours_left;

  modport source (output valid, output service_watchdog, output reset_now, output failed,
                  output report_valid, output tasks_running, output uplink_hours_left,
                  input ready);
  modport sink   (input valid, input service_watchdog, input reset_now, input failed,
                  input report_valid, input tasks_running, input uplink_hours_left,
                  output ready);
endinterface

[hw/rtl/multi_task_heartbeat_watchdog.sv]
// Multi-task heartbeat watchdog top level: input register, update core, result register,
// APB register file. Depends on hbw_pkg, hbw_in_if, hbw_out_if, hbw_cfg, hbw_core.
//
// Takes one operation beat per clock while in_beat.ready is high and returns exactly one
// result beat for each, after the input register and then the result register. The state
// update in hbw_core is combinational, so beats need not wait on each other;
// in_beat.ready drops only when both registers hold beats the sink has not
// taken. Periods written over APB (0x0 heartbeat seconds, 0x4 uplink hours) take effect
// at the next reload of the matching countdown; write them only while the block is idle.
module multi_task_heartbeat_watchdog #(
  parameter int NUM_TASKS = hbw_pkg::NUM_TASKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  hbw_in_if.sink                        in_beat,
  hbw_out_if.source                     out_beat,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hbw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [hbw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [hbw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready
);
  import hbw_pkg::*;

  cfg_t             cfg;
  res_t             res;
  res_t             res_r;
  logic             s1_valid_r;
  op_t              s1_op_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s2_valid_r;
  logic             advance;

  assign advance       = s1_valid_r && (!s2_valid_r || out_beat.ready);
  assign in_beat.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_beat.valid && in_beat.ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat.valid && in_beat.ready) begin
      s1_op_r  <= op_t'(in_beat.operation);
      s1_idx_r <= in_beat.task_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= 1'b1;
    end else if (out_beat.ready) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  hbw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hbw_core #(
    .NUM_TASKS (NUM_TASKS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .fire       (advance),
    .op         (s1_op_r),
    .task_index (s1_idx_r),
    .res        (res)
  );

  assign out_beat.valid             = s2_valid_r;
  assign out_beat.service_watchdog  = res_r.service_watchdog;
  assign out_beat.reset_now         = res_r.reset_now;
  assign out_beat.failed            = res_r.failed;
  assign out_beat.report_valid      = res_r.report_valid;
  assign out_beat.tasks_running     = res_r.tasks_running;
  assign out_beat.uplink_hours_left = res_r.uplink_hours_left;
endmodule

[hw/rtl/hbw_cfg.sv]
// APB-style register file for the heartbeat and uplink periods.
// Depends on hbw_pkg (cfg_t, register indexes).
module hbw_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hbw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [hbw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [hbw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  output hbw_pkg::cfg_t                 cfg
);
  import hbw_pkg::*;

  logic [HB_S_W-1:0] hb_s_r;
  logic [UP_H_W-1:0] up_h_r;
  logic              wr_en;
  reg_idx_t          sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_s_r <= HB_S_W'(HB_RST_S);
      up_h_r <= UP_H_W'(UP_RST_H);
    end else if (wr_en) begin
      case (sel)
        REG_HB_PERIOD: hb_s_r <= pwdata[HB_S_W-1:0];
        REG_UP_PERIOD: up_h_r <= pwdata[UP_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_HB_PERIOD: prdata = CFG_DATA_W'(hb_s_r);
      REG_UP_PERIOD: prdata = CFG_DATA_W'(up_h_r);
      default:       prdata = '0;
    endcase
  end

  assign cfg.hb_period_s = hb_s_r;
  assign cfg.up_period_h = up_h_r;
endmodule

[hw/rtl/hbw_core.sv]
// Watchdog state and single-pass update: task masks, heartbeat and uplink countdowns.
// Depends on hbw_pkg (op_t, cfg_t, res_t). State advances on each fire.
module hbw_core #(
  parameter int NUM_TASKS = hbw_pkg::NUM_TASKS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  hbw_pkg::cfg_t            cfg,
  input  logic                     fire,
  input  hbw_pkg::op_t             op,
  input  logic [hbw_pkg::IDX_W-1:0] task_index,
  output hbw_pkg::res_t            res
);
  import hbw_pkg::*;

  localparam logic [UP_SUB_W-1:0] SUB_LAST = UP_SUB_W'(TICKS_PER_HOUR - 1);

  logic [NUM_TASKS-1:0] watched_r, watched_nxt;
  logic [NUM_TASKS-1:0] alive_r, alive_nxt;
  logic [HB_CNT_W-1:0]  hb_cnt_r, hb_cnt_nxt;
  logic [UP_H_W-1:0]    up_hours_r, up_hours_nxt;
  logic [UP_SUB_W-1:0]  up_sub_r, up_sub_nxt;
  logic                 fail_r, fail_nxt;

  logic [NUM_TASKS-1:0]       task_bit;
  logic [NUM_TASKS-1:0]       running;
  logic [NUM_TASKS+RUN_W-1:0] run_ext;
  logic [HB_S_W-1:0]          hb_s;
  logic [UP_H_W-1:0]          up_h;
  logic [HB_CNT_W-1:0]        hb_reload;

  always_comb begin
    for (int i = 0; i < NUM_TASKS; i++) begin
      task_bit[i] = (32'(task_index) == i);
    end
  end

  assign hb_s      = (cfg.hb_period_s < HB_S_W'(MIN_HB_S)) ? HB_S_W'(MIN_HB_S) : cfg.hb_period_s;
  assign up_h      = (cfg.up_period_h < UP_H_W'(MIN_UP_H)) ? UP_H_W'(MIN_UP_H) : cfg.up_period_h;
  assign hb_reload = HB_CNT_W'(hb_s) * HB_CNT_W'(TICKS_PER_SEC);

  always_comb begin
    watched_nxt  = watched_r;
    alive_nxt    = alive_r;
    hb_cnt_nxt   = hb_cnt_r;
    up_hours_nxt = up_hours_r;
    up_sub_nxt   = up_sub_r;
    fail_nxt     = fail_r;
    running      = '0;
    res          = '0;
    case (op)
      OP_TICK: begin
        if (up_hours_r == '0 && up_sub_r <= UP_SUB_W'(1)) begin
          fail_nxt     = 1'b1;
          up_hours_nxt = up_h;
          up_sub_nxt   = '0;
        end else if (up_sub_r == '0) begin
          up_hours_nxt = up_hours_r - UP_H_W'(1);
          up_sub_nxt   = SUB_LAST;
        end else begin
          up_sub_nxt   = up_sub_r - UP_SUB_W'(1);
        end
        if (hb_cnt_r <= HB_CNT_W'(1)) begin
          hb_cnt_nxt = hb_reload;
          if (!fail_nxt) begin
            if (|(watched_r & ~alive_r)) begin
              fail_nxt      = 1'b1;
              res.reset_now = 1'b1;
            end
            running          = watched_r & alive_r;
            alive_nxt        = '0;
            res.report_valid = 1'b1;
          end
        end else begin
          hb_cnt_nxt = hb_cnt_r - HB_CNT_W'(1);
        end
        res.service_watchdog = !fail_nxt;
      end
      OP_HEARTBEAT:  alive_nxt   = alive_r | task_bit;
      OP_REGISTER:   watched_nxt = watched_r | task_bit;
      OP_UNREGISTER: watched_nxt = watched_r & ~task_bit;
      OP_DISABLE: begin
        watched_nxt = '0;
        alive_nxt   = '0;
      end
      OP_KICK: begin
        up_hours_nxt = up_h;
        up_sub_nxt   = '0;
      end
      default: ;
    endcase
    run_ext               = {{RUN_W{1'b0}}, running};
    res.tasks_running     = run_ext[RUN_W-1:0];
    res.failed            = fail_nxt;
    res.uplink_hours_left = up_hours_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      watched_r  <= '0;
      alive_r    <= '1;
      hb_cnt_r   <= HB_CNT_W'(HB_RST_S * TICKS_PER_SEC);
      up_hours_r <= UP_H_W'(UP_RST_H);
      up_sub_r   <= '0;
      fail_r     <= 1'b0;
    end else if (fire) begin
      watched_r  <= watched_nxt;
      alive_r    <= alive_nxt;
      hb_cnt_r   <= hb_cnt_nxt;
      up_hours_r <= up_hours_nxt;
      up_sub_r   <= up_sub_nxt;
      fail_r     <= fail_nxt;
    end
  end

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fail_r |=> fail_r)
    else $error("failure latch cleared");

  a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
    up_sub_r <= SUB_LAST)
    else $error("uplink sub-hour count out of range");

  a_hb_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    hb_cnt_r != '0)
    else $error("heartbeat countdown reached zero");

  a_reset_report: assert property (@(posedge clk) disable iff (!rst_n)
    res.reset_now |-> (res.report_valid && res.failed && !res.service_watchdog))
    else $error("reset request without a failed check");

  a_service_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.service_watchdog) |=> !fail_r)
    else $error("watchdog serviced with failure latched");
endmodule
